// ----- sv/brf_pkg.sv -----
// Shared types and constants of the byte ring FIFO.
package brf_pkg;

  localparam int CAP_W = 13;
  localparam int LEN_W = 7;
  localparam int BYTE_W = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUSH_ACC = 2'd0,
    KIND_PUSH_REJ = 2'd1,
    KIND_POP_DATA = 2'd2,
    KIND_POP_REJ  = 2'd3
  } kind_e;

  // Classified transaction handed from the front part to the back part.
  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   len;
    logic [CAP_W-1:0]   fill;
  } cmd_info_t;

  // Back part status seen by the front part.
  typedef struct packed {
    logic busy;
    logic pop_deq;
  } back_status_t;

endpackage

// ----- sv/brf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/brf_queue.sv -----
// Short register queue between the front and back parts.
module brf_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

// ----- sv/brf_front.sv -----
// Front part: accepts items, keeps the FIFO bookkeeping and writes push bytes.
module brf_front #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_TRANSFER = 64,
  localparam int IDX_W = $clog2(STORE_DEPTH),
  localparam int SUM_W = ((IDX_W > brf_pkg::CAP_W) ? IDX_W : brf_pkg::CAP_W) + 1,
  localparam int PCNT_W = $clog2(brf_pkg::QUEUE_DEPTH + 2)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic                        first_of_message_i,
  input  logic [brf_pkg::LEN_W-1:0]   msg_len_i,
  input  logic [brf_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output brf_pkg::cmd_info_t          q_info_o,
  output logic [IDX_W-1:0]            q_idx_o,
  input  brf_pkg::back_status_t       back_st_i,
  output logic [brf_pkg::CAP_W-1:0]   cap_eff_o,
  output logic                        ram_we_o,
  output logic [IDX_W-1:0]            ram_waddr_o,
  output logic [brf_pkg::BYTE_W-1:0]  ram_wdata_o
);

  logic [brf_pkg::CAP_W-1:0] capacity_q;
  logic [IDX_W-1:0]          read_idx_q, read_idx_d;
  logic [IDX_W-1:0]          commit_idx_q, commit_idx_d;
  logic [IDX_W-1:0]          write_idx_q, write_idx_d;
  logic [brf_pkg::CAP_W-1:0] held_q, held_d;
  logic [brf_pkg::LEN_W-1:0] due_q, due_d;
  logic                      acc_q, acc_d;
  logic [brf_pkg::LEN_W-1:0] pend_q, pend_d;
  logic [PCNT_W-1:0]         pop_cnt_q, pop_cnt_d;

  logic [brf_pkg::CAP_W-1:0] cap_eff, free_space, len_ext;
  logic                      len_ok, in_acc, hazard;
  logic [IDX_W-1:0]          eff_widx, widx_next, ridx_next;
  logic [brf_pkg::LEN_W-1:0] eff_due, eff_pend, pend_inc;
  logic                      eff_acc;
  logic [SUM_W-1:0]          w_sum, r_sum;
  brf_pkg::kind_e            kind_d;

  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = brf_pkg::CAP_W'(1);
    end else if (32'(capacity_q) > STORE_DEPTH) begin
      cap_eff = brf_pkg::CAP_W'(STORE_DEPTH);
    end else begin
      cap_eff = capacity_q;
    end
  end

  assign cap_eff_o = cap_eff;

  // Pushes wait while any pop is queued or still being read, so a write can
  // never land on a byte that a pop has released but not yet fetched.
  assign hazard     = (pop_cnt_q != '0) || back_st_i.busy;
  assign in_stall_o = q_full_i || ((cmd_i == brf_pkg::CMD_PUSH) && hazard);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign len_ext    = brf_pkg::CAP_W'(msg_len_i);
  assign len_ok     = (msg_len_i != '0) && (32'(msg_len_i) <= MAX_TRANSFER);
  assign free_space = cap_eff - held_q;

  assign eff_widx = first_of_message_i ? commit_idx_q : write_idx_q;
  assign eff_due  = first_of_message_i ? msg_len_i : due_q;
  assign eff_pend = first_of_message_i ? '0 : pend_q;
  assign eff_acc  = first_of_message_i ? (len_ok && (len_ext <= free_space)) : acc_q;
  assign pend_inc = eff_pend + 1'b1;

  assign w_sum     = SUM_W'(eff_widx) + SUM_W'(1);
  assign widx_next = (w_sum >= SUM_W'(cap_eff)) ? '0 : IDX_W'(w_sum);
  assign r_sum     = SUM_W'(read_idx_q) + SUM_W'(msg_len_i);
  assign ridx_next = (r_sum >= SUM_W'(cap_eff)) ? IDX_W'(r_sum - SUM_W'(cap_eff))
                                                : IDX_W'(r_sum);

  always_comb begin
    read_idx_d   = read_idx_q;
    commit_idx_d = commit_idx_q;
    write_idx_d  = write_idx_q;
    held_d       = held_q;
    due_d        = due_q;
    acc_d        = acc_q;
    pend_d       = pend_q;
    kind_d       = brf_pkg::KIND_PUSH_REJ;
    ram_we_o     = 1'b0;
    if (cmd_i == brf_pkg::CMD_POP) begin
      if (!len_ok || (len_ext > held_q)) begin
        kind_d = brf_pkg::KIND_POP_REJ;
      end else begin
        kind_d     = brf_pkg::KIND_POP_DATA;
        held_d     = held_q - len_ext;
        read_idx_d = ridx_next;
      end
    end else if (first_of_message_i || (due_q != '0)) begin
      write_idx_d = eff_widx;
      pend_d      = eff_pend;
      acc_d       = eff_acc;
      due_d       = (eff_due == '0) ? '0 : eff_due - 1'b1;
      if (eff_acc) begin
        kind_d      = brf_pkg::KIND_PUSH_ACC;
        ram_we_o    = in_acc;
        write_idx_d = widx_next;
        pend_d      = pend_inc;
        if (due_d == '0) begin
          // Last byte of the message: make the whole message visible.
          commit_idx_d = widx_next;
          held_d       = held_q + brf_pkg::CAP_W'(pend_inc);
          pend_d       = '0;
          acc_d        = 1'b0;
        end
      end
    end
  end

  assign ram_waddr_o = eff_widx;
  assign ram_wdata_o = data_byte_i;

  assign q_push_o      = in_acc;
  assign q_info_o.kind = kind_d;
  assign q_info_o.len  = msg_len_i;
  assign q_info_o.fill = held_d;
  assign q_idx_o       = read_idx_q;

  always_comb begin
    pop_cnt_d = pop_cnt_q;
    if (in_acc && (kind_d == brf_pkg::KIND_POP_DATA)) begin
      pop_cnt_d = pop_cnt_d + 1'b1;
    end
    if (back_st_i.pop_deq) begin
      pop_cnt_d = pop_cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q   <= brf_pkg::CAP_RESET;
      read_idx_q   <= '0;
      commit_idx_q <= '0;
      write_idx_q  <= '0;
      held_q       <= '0;
      due_q        <= '0;
      acc_q        <= 1'b0;
      pend_q       <= '0;
      pop_cnt_q    <= '0;
    end else begin
      pop_cnt_q <= pop_cnt_d;
      if (cfg_we_i) begin
        capacity_q   <= cfg_wdata_i;
        read_idx_q   <= '0;
        commit_idx_q <= '0;
        write_idx_q  <= '0;
        held_q       <= '0;
        due_q        <= '0;
        acc_q        <= 1'b0;
        pend_q       <= '0;
      end else if (in_acc) begin
        read_idx_q   <= read_idx_d;
        commit_idx_q <= commit_idx_d;
        write_idx_q  <= write_idx_d;
        held_q       <= held_d;
        due_q        <= due_d;
        acc_q        <= acc_d;
        pend_q       <= pend_d;
      end
    end
  end

endmodule

// ----- sv/brf_back.sv -----
// Back part: expands queued transactions into results and reads popped bytes.
module brf_back #(
  parameter int STORE_DEPTH = 4096,
  localparam int IDX_W = $clog2(STORE_DEPTH),
  localparam int SUM_W = ((IDX_W > brf_pkg::CAP_W) ? IDX_W : brf_pkg::CAP_W) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [brf_pkg::CAP_W-1:0]   cap_eff_i,
  input  logic                        q_valid_i,
  input  brf_pkg::cmd_info_t          q_info_i,
  input  logic [IDX_W-1:0]            q_idx_i,
  output logic                        q_pop_o,
  output brf_pkg::back_status_t       st_o,
  output logic                        ram_re_o,
  output logic [IDX_W-1:0]            ram_raddr_o,
  input  logic [brf_pkg::BYTE_W-1:0]  ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [brf_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_of_run_o,
  output logic [brf_pkg::CAP_W-1:0]   fill_level_o
);

  logic                      out_valid_q, busy_q, last_q;
  brf_pkg::kind_e            kind_q;
  logic [brf_pkg::CAP_W-1:0] out_fill_q, run_fill_q;
  logic [brf_pkg::LEN_W-1:0] rem_q;
  logic [IDX_W-1:0]          ridx_q, nidx;
  logic [SUM_W-1:0]          r_sum;
  logic                      adv;

  // The output register frees up when empty or when its result is taken.
  assign adv = !out_valid_q || !out_stall_i;

  always_comb begin
    q_pop_o     = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = ridx_q;
    if (adv) begin
      if (busy_q) begin
        ram_re_o = 1'b1;
      end else if (q_valid_i) begin
        q_pop_o = 1'b1;
        if (q_info_i.kind == brf_pkg::KIND_POP_DATA) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = q_idx_i;
        end
      end
    end
  end

  assign r_sum = SUM_W'(ram_raddr_o) + SUM_W'(1);
  assign nidx  = (r_sum >= SUM_W'(cap_eff_i)) ? '0 : IDX_W'(r_sum);

  assign st_o.busy    = busy_q;
  assign st_o.pop_deq = q_pop_o && (q_info_i.kind == brf_pkg::KIND_POP_DATA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
    end else if (adv) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        kind_q      <= brf_pkg::KIND_POP_DATA;
        last_q      <= (rem_q == brf_pkg::LEN_W'(1));
        out_fill_q  <= run_fill_q;
        ridx_q      <= nidx;
        rem_q       <= rem_q - 1'b1;
        busy_q      <= (rem_q != brf_pkg::LEN_W'(1));
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        kind_q      <= q_info_i.kind;
        out_fill_q  <= q_info_i.fill;
        run_fill_q  <= q_info_i.fill;
        if (q_info_i.kind == brf_pkg::KIND_POP_DATA) begin
          last_q <= (q_info_i.len == brf_pkg::LEN_W'(1));
          ridx_q <= nidx;
          rem_q  <= q_info_i.len - 1'b1;
          busy_q <= (q_info_i.len != brf_pkg::LEN_W'(1));
        end else begin
          last_q <= 1'b1;
        end
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = (kind_q == brf_pkg::KIND_POP_DATA) ? ram_rdata_i : '0;
  assign last_of_run_o = last_q;
  assign fill_level_o  = out_fill_q;

endmodule

// ----- sv/byte_ring_fifo_atomic_transfer_core.sv -----
// Top level: circular byte FIFO with all-or-nothing push messages.
// Throughput: push bytes go one per cycle, and a pop of N bytes emits one byte per
// cycle while the result side does not stall. A push waits while a pop is queued or
// being read out, and any transaction waits while the four-entry queue is full, as
// during a long pop run or result stalls.
// Reset: asynchronous and active low; it empties the FIFO and sets capacity to 4096.
module byte_ring_fifo_atomic_transfer_core #(
  parameter int STORE_DEPTH = 4096,
  parameter int MAX_TRANSFER = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic                        first_of_message_i,
  input  logic [brf_pkg::LEN_W-1:0]   msg_len_i,
  input  logic [brf_pkg::BYTE_W-1:0]  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [brf_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_of_run_o,
  output logic [brf_pkg::CAP_W-1:0]   fill_level_o
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int QDATA_W = $bits(brf_pkg::cmd_info_t) + IDX_W;

  // The front part decides every transaction on its own: it judges push
  // messages against the free space, writes accepted bytes into the store,
  // checks pop sizes against the fill level and moves the indexes. Each
  // transaction leaves it as one queue entry that already carries its result
  // kind, the fill level to report and, for pops, the start read index.
  //
  // The back part turns each entry into results. A pop entry becomes a run of
  // reads, one per cycle, whose data lands straight in the store's read
  // register, which doubles as the byte field of the output register. The
  // read is issued only when the output register is free or being emptied, so
  // a stall on the result side simply freezes the read register. The byte
  // store is never cleared, since only committed bytes are ever read.

  logic                      q_full, q_push, q_pop, q_valid;
  brf_pkg::cmd_info_t        front_info, back_info;
  logic [IDX_W-1:0]          front_idx, back_idx;
  logic [QDATA_W-1:0]        q_wdata, q_rdata;
  brf_pkg::back_status_t     back_st;
  logic [brf_pkg::CAP_W-1:0] cap_eff;

  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr;
  logic [brf_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  brf_front #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .first_of_message_i (first_of_message_i),
    .msg_len_i          (msg_len_i),
    .data_byte_i        (data_byte_i),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_info_o           (front_info),
    .q_idx_o            (front_idx),
    .back_st_i          (back_st),
    .cap_eff_o          (cap_eff),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata)
  );

  assign q_wdata = {front_info, front_idx};

  brf_queue #(
    .DATA_W (QDATA_W),
    .DEPTH  (brf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign back_info = q_rdata[QDATA_W-1:IDX_W];
  assign back_idx  = q_rdata[IDX_W-1:0];

  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_eff_i     (cap_eff),
    .q_valid_i     (q_valid),
    .q_info_i      (back_info),
    .q_idx_i       (back_idx),
    .q_pop_o       (q_pop),
    .st_o          (back_st),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .fill_level_o  (fill_level_o)
  );

endmodule

// ----- tb/byte_ring_fifo_atomic_transfer_core_tb.sv -----
// Self-checking testbench for the byte ring FIFO with all-or-nothing push messages.
module byte_ring_fifo_atomic_transfer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int MAX_XFER = 64;
  // Quiet time after draining lets anything unexpected show up before a register
  // write or the end.
  localparam int SETTLE_CYCLES = 8;

  // One result as the block should present it.
  typedef struct packed {
    kind_e            kind;
    logic [BYTE_W-1:0] data;
    logic             last;
    logic [CAP_W-1:0] fill;
  } fifo_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CAP_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              cmd_i;
  logic              first_of_message_i;
  logic [LEN_W-1:0]  msg_len_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        kind_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_of_run_o;
  logic [CAP_W-1:0]  fill_level_o;

  byte_ring_fifo_atomic_transfer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .first_of_message_i (first_of_message_i),
    .msg_len_i          (msg_len_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .out_byte_o         (out_byte_o),
    .last_of_run_o      (last_of_run_o),
    .fill_level_o       (fill_level_o)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // FIFO predictor. This is an independent copy of the FIFO state, updated in
  // the order the block accepts transactions.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_mem [0:STORE_DEPTH-1];
  logic [11:0]       head_idx;     // next byte to pop
  logic [11:0]       commit_idx;   // end of the committed bytes
  logic [11:0]       tail_idx;     // next write of the open message
  logic [CAP_W-1:0]  held_bytes;   // committed fill level
  logic [LEN_W-1:0]  due_bytes;    // bytes of the open message still to come
  logic              msg_ok;       // open message was accepted
  logic [LEN_W-1:0]  pend_bytes;   // bytes of the open message written so far
  logic [CAP_W-1:0]  cap_reg;

  fifo_result_t expected_results [$];
  int           errors = 0;
  int           items_sent = 0;
  int           burst_left = 0;

  // A capacity of zero behaves as one; anything above the store depth is
  // clamped to the store depth.
  function automatic int eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > STORE_DEPTH) return STORE_DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic logic [11:0] step_idx(input logic [11:0] idx);
    int n;
    n = int'(idx) + 1;
    return (n >= eff_cap()) ? 12'd0 : 12'(n);
  endfunction

  // Reset and every capacity write empty the FIFO and drop an open message.
  task automatic clear_ring_state();
    head_idx   = '0;
    commit_idx = '0;
    tail_idx   = '0;
    held_bytes = '0;
    due_bytes  = '0;
    msg_ok     = 1'b0;
    pend_bytes = '0;
  endtask

  task automatic expect_result(input kind_e k, input logic [BYTE_W-1:0] b, input logic l);
    fifo_result_t r;
    r.kind = k;
    r.data = b;
    r.last = l;
    r.fill = held_bytes;
    expected_results.push_back(r);
  endtask

  // Work out the results of one accepted transaction.
  task automatic predict_item(input logic c, input logic f, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] d);
    int free_sp;
    if (c == CMD_POP) begin
      // A pop sees only committed bytes and is all-or-nothing.
      if (len == 0 || len > MAX_XFER || len > held_bytes) begin
        expect_result(KIND_POP_REJ, '0, 1'b1);
        return;
      end
      held_bytes = held_bytes - len;
      for (int i = 0; i < int'(len); i++) begin
        expect_result(KIND_POP_DATA, ring_mem[head_idx], (i + 1) == int'(len));
        head_idx = step_idx(head_idx);
      end
      return;
    end
    if (f) begin
      // A new first byte abandons any open message and judges the new one
      // against the committed free space.
      free_sp    = (eff_cap() > int'(held_bytes)) ? eff_cap() - int'(held_bytes) : 0;
      tail_idx   = commit_idx;
      pend_bytes = '0;
      msg_ok     = (len != 0) && (len <= MAX_XFER) && (int'(len) <= free_sp);
      due_bytes  = len;
    end else if (due_bytes == 0) begin
      // Stray byte outside any message.
      expect_result(KIND_PUSH_REJ, '0, 1'b1);
      return;
    end
    if (due_bytes > 0) due_bytes = due_bytes - 1'b1;
    if (!msg_ok) begin
      expect_result(KIND_PUSH_REJ, '0, 1'b1);
      return;
    end
    ring_mem[tail_idx] = d;
    tail_idx   = step_idx(tail_idx);
    pend_bytes = pend_bytes + 1'b1;
    if (due_bytes == 0) begin
      // The last byte commits the whole message at once.
      commit_idx = tail_idx;
      held_bytes = held_bytes + pend_bytes;
      pend_bytes = '0;
      msg_ok     = 1'b0;
    end
    expect_result(KIND_PUSH_ACC, '0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the result checker.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Every result accepted by the receiver is compared with the oldest
  // expectation. Outputs are sampled right at the clock edge, before any
  // nonblocking update of this time step takes effect.
  always @(posedge clk_i) begin : check_results
    fifo_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing expected", kind_o));
      end else begin
        want = expected_results.pop_front();
        if (kind_o !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind_o, want.kind));
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("out_byte got %0h want %0h", out_byte_o, want.data));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run got %0b want %0b", last_of_run_o, want.last));
        if (fill_level_o !== want.fill)
          report_mismatch($sformatf("fill_level got %0d want %0d", fill_level_o, want.fill));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern. The receiver switches between modes at random: no
  // stall at all, light random stalls, heavy random stalls, and a regular on/off
  // rhythm.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_left % 3 == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender. One transaction is driven and held until accepted; the sender
  // works in bursts, dropping valid for a random gap between them. Some
  // bursts are long and have no gap, so back-to-back traffic is covered too.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic c, input logic f, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] d);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 90);
      end else begin
        burst_left = $urandom_range(1, 8);
        gap = $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i         <= 1'b1;
    cmd_i              <= c;
    first_of_message_i <= f;
    msg_len_i          <= len;
    data_byte_i        <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(c, f, len, d);
    items_sent++;
  endtask

  // Pause the sender until every expected result has come, then give the
  // block a quiet settling time.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The capacity register is only written while the block is idle. The write
  // empties the FIFO and drops any open message in both the block and the
  // predictor.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = value;
    clear_ring_state();
    repeat (2) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic helpers.
  // ---------------------------------------------------------------------------
  function automatic int min_int(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // A pop mostly asks for a size that is available; sometimes any size,
  // including zero and sizes beyond the transfer limit.
  task automatic pop_random();
    int len;
    if (held_bytes != 0 && $urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 9) == 0) len = min_int(int'(held_bytes), MAX_XFER);
      else len = $urandom_range(1, min_int(int'(held_bytes), MAX_XFER));
    end else begin
      len = $urandom_range(0, 127);
    end
    send_item(CMD_POP, 1'($urandom), LEN_W'(len), BYTE_W'($urandom));
  endtask

  // Send the first n_sent bytes of a push message of length len. Now and
  // then a pop slips in while the message is open. Bytes after the first
  // carry random length fields, which the block must ignore.
  task automatic push_message(input int len, input int n_sent);
    for (int i = 0; i < n_sent; i++) begin
      if (i > 0 && $urandom_range(0, 19) == 0) pop_random();
      send_item(CMD_PUSH, i == 0, (i == 0) ? LEN_W'(len) : LEN_W'($urandom),
                BYTE_W'($urandom));
    end
  endtask

  // Choose a message length: mostly one that fits, biased toward short ones.
  function automatic int pick_push_len();
    int free_sp;
    int max_fit;
    free_sp = (eff_cap() > int'(held_bytes)) ? eff_cap() - int'(held_bytes) : 0;
    max_fit = min_int(free_sp, MAX_XFER);
    if (max_fit == 0 || $urandom_range(0, 9) == 0) return $urandom_range(1, MAX_XFER);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, max_fit);
    return $urandom_range(1, min_int(6, max_fit));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // On an empty FIFO every pop is rejected, a byte outside a message is
  // rejected, and a message of length zero is rejected.
  task automatic test_empty_rejects();
    send_item(CMD_POP, 1'b0, 7'd0, 8'h00);
    send_item(CMD_POP, 1'b1, 7'd1, 8'hFF);
    send_item(CMD_PUSH, 1'b0, 7'd0, 8'hFF);
    send_item(CMD_PUSH, 1'b1, 7'd0, 8'h5A);
  endtask

  // Lengths above the transfer limit are rejected for pushes and pops; a new
  // first byte abandons a rejected message and is judged on its own.
  task automatic test_length_limits();
    send_item(CMD_PUSH, 1'b1, 7'd127, 8'hFF);
    send_item(CMD_PUSH, 1'b0, 7'd127, 8'h00);
    send_item(CMD_PUSH, 1'b1, 7'd65, 8'h3C);
    send_item(CMD_PUSH, 1'b1, 7'd2, 8'hA5);
    send_item(CMD_PUSH, 1'b0, 7'd0, 8'h5A);
    send_item(CMD_POP, 1'b0, 7'd127, 8'h00);
    send_item(CMD_POP, 1'b0, 7'd65, 8'h00);
    send_item(CMD_POP, 1'b0, 7'd3, 8'h00);
  endtask

  // A pop during an open message sees only committed bytes; a new first byte
  // during an open message discards its uncommitted bytes.
  task automatic test_open_message();
    send_item(CMD_PUSH, 1'b1, 7'd3, 8'h00);
    send_item(CMD_PUSH, 1'b0, 7'd0, 8'hFF);
    send_item(CMD_POP, 1'b0, 7'd2, 8'h00);
    send_item(CMD_POP, 1'b0, 7'd1, 8'h00);
    send_item(CMD_PUSH, 1'b1, 7'd2, 8'h11);
    send_item(CMD_PUSH, 1'b0, 7'd0, 8'h22);
    send_item(CMD_POP, 1'b0, 7'd2, 8'h00);
  endtask

  // Capacity zero acts as a single byte of storage: the FIFO fills with one
  // byte and a message that does not fit is rejected byte by byte.
  task automatic test_tiny_capacity();
    set_capacity(13'd0);
    send_item(CMD_PUSH, 1'b1, 7'd1, 8'h80);
    send_item(CMD_PUSH, 1'b1, 7'd1, 8'h01);
    send_item(CMD_POP, 1'b0, 7'd1, 8'h00);
    send_item(CMD_PUSH, 1'b1, 7'd2, 8'h7F);
    send_item(CMD_PUSH, 1'b0, 7'd0, 8'hFE);
  endtask

  // Random traffic at one capacity. Most of it is well-formed messages and
  // pops; the rest is truncated messages, over-length messages, stray bytes,
  // zero-length messages and fully random transactions.
  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int n_items);
    int target;
    int r;
    int len;
    set_capacity(cap);
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        len = pick_push_len();
        push_message(len, len);
      end else if (r < 58) begin
        len = $urandom_range(2, MAX_XFER);
        push_message(len, $urandom_range(1, min_int(len - 1, 8)));
      end else if (r < 83) begin
        pop_random();
      end else if (r < 88) begin
        len = $urandom_range(MAX_XFER + 1, 127);
        push_message(len, $urandom_range(1, 3));
      end else if (r < 93) begin
        send_item(CMD_PUSH, 1'b0, LEN_W'($urandom), BYTE_W'($urandom));
      end else if (r < 96) begin
        send_item(CMD_PUSH, 1'b1, 7'd0, BYTE_W'($urandom));
      end else begin
        send_item(1'($urandom), 1'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
      end
      // Occasionally hold off the sender until everything has come back.
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_valid_i         <= 1'b0;
    cmd_i              <= CMD_PUSH;
    first_of_message_i <= 1'b0;
    msg_len_i          <= '0;
    data_byte_i        <= '0;
    out_stall_i        <= 1'b0;
    cap_reg = CAP_RESET;
    clear_ring_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_rejects();
    test_length_limits();
    test_open_message();
    // The sender waits here for every outstanding result at least once.
    drain_results();
    test_tiny_capacity();

    test_random_traffic(13'd1, 20);
    test_random_traffic(13'd2, 20);
    test_random_traffic(13'd3, 20);
    test_random_traffic(13'd17, 25);
    test_random_traffic(13'd64, 25);
    test_random_traffic(13'd65, 25);
    test_random_traffic(13'd4096, 30);
    test_random_traffic(13'd8191, 25);
    test_random_traffic(13'd5000, 20);
    test_random_traffic(13'd0, 15);
    test_random_traffic(13'd100, 25);

    drain_results();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
